@@ rtl/dosc_pkg.sv @@
// shared types and constants for the damped oscillator acceleration response block
package dosc_pkg;

   // configuration register indexes
   localparam logic [7:0] REG_NATURAL_FREQ  = 8'd0;
   localparam logic [7:0] REG_DAMPING_RATIO = 8'd1;

   localparam logic [24:0] NATURAL_FREQ_RST  = 25'd411775;
   localparam logic [15:0] DAMPING_RATIO_RST = 16'd3277;

   // fixed-point constants
   localparam logic [31:0] TURN_PER_RAD_Q32 = 32'd683565276;
   localparam logic [31:0] TWO_PI_Q29       = 32'd3373259426;
   localparam logic [29:0] INV_E_Q30        = 30'd395007542;
   localparam logic [30:0] ONE_Q30          = 31'd1073741824;
   localparam int          EXP_CUTOFF       = 23;
   localparam int          TAYLOR_STEPS     = 13;
   localparam int          TRIG_STEPS       = 7;

   // quadrant codes of the phase
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // coefficient sequencer
   typedef enum logic [5:0] {
      SEQ_IDLE = 6'b000001,
      SEQ_XW   = 6'b000010,
      SEQ_ROOT = 6'b000100,
      SEQ_WD   = 6'b001000,
      SEQ_SQ   = 6'b010000,
      SEQ_COEF = 6'b100000
   } seq_state_type;

   // one beat in the series stages
   typedef struct packed {
      logic               vld;
      logic               neg;
      logic               cut;
      logic [1:0]         quad;
      logic [4:0]         k;
      logic [31:0]        x2;
      logic [32:0]        ts;
      logic [32:0]        tc;
      logic signed [32:0] ss;
      logic signed [32:0] cs;
      logic [29:0]        f;
      logic [30:0]        et;
      logic signed [31:0] es;
   } tay_type;

   // one beat in the decay stages
   typedef struct packed {
      logic               vld;
      logic               neg;
      logic [4:0]         k;
      logic [30:0]        e;
      logic signed [33:0] sv;
      logic signed [33:0] cv;
   } dec_type;

endpackage

@@ rtl/damped_oscillator_accel_response.sv @@
// top level: damped oscillator acceleration impulse response pipeline
//
// Evaluates the acceleration impulse response of a damped single-degree-of-freedom
// oscillator at a signed Q16.16 time per request beat and returns a Q31.16
// amplitude with a saturation flag; negative times give zero. The datapath is a
// fixed pipeline of 63 register stages (input, phase and decay products, turn
// conversion, turn sum, quadrant angle, series seed, thirteen Taylor steps of two
// stages each with exp(-f) in every step and sine and cosine in the first seven,
// quadrant unfold, 22 conditional e^-1 multiply stages, seven stages of coefficient
// and decay products, and the output register), so one beat is accepted every cycle
// while req_ready is high. Backpressure on the response side freezes the whole
// pipeline, bubbles included. The derived coefficients (xi*wn, wd via a bit-serial
// square root, and the sine and cosine weights) are computed by a small sequencer
// after reset and after every register write, one root bit per cycle, during which
// req_ready is low.
module damped_oscillator_accel_response #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_time_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_amplitude,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import dosc_pkg::*;

   // shift that brings a 2F-fraction product to 32 fraction bits
   localparam int Sh  = 2 * FRAC_BITS - 32;
   localparam int ShR = (Sh >= 0) ? Sh : 0;
   localparam int ShL = (Sh < 0) ? -Sh : 0;
   localparam int DecStages = EXP_CUTOFF - 1;

   // ---------------------------------------------------------------
   // configuration registers and coefficient sequencer
   // ---------------------------------------------------------------
   logic [24:0]   natural_freq_ff, natural_freq_in;
   logic [15:0]   damping_ratio_ff, damping_ratio_in;
   seq_state_type state_ff, state_in;
   logic [24:0]   xw_ff, xw_in;
   logic [63:0]   rem_ff, rem_in;
   logic [63:0]   res_ff, res_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [24:0]   wd_ff, wd_in;
   logic [49:0]   xsq_ff, xsq_in;
   logic [49:0]   wsq_ff, wsq_in;
   logic [39:0]   cc_mag_ff, cc_mag_in;
   logic [39:0]   cs_mag_ff, cs_mag_in;
   logic          cs_neg_ff, cs_neg_in;

   logic          csr_write;
   logic [63:0]   root_bit;
   logic [63:0]   root_trial;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      natural_freq_in  = natural_freq_ff;
      damping_ratio_in = damping_ratio_ff;
      state_in         = state_ff;
      xw_in            = xw_ff;
      rem_in           = rem_ff;
      res_in           = res_ff;
      cnt_in           = cnt_ff;
      wd_in            = wd_ff;
      xsq_in           = xsq_ff;
      wsq_in           = wsq_ff;
      cc_mag_in        = cc_mag_ff;
      cs_mag_in        = cs_mag_ff;
      cs_neg_in        = cs_neg_ff;
      root_bit         = 64'd1 << (7'd62 - {1'b0, cnt_ff, 1'b0});
      root_trial       = res_ff + root_bit;
      case (state_ff)
         SEQ_IDLE: begin
         end
         SEQ_XW: begin
            xw_in  = 25'((41'(damping_ratio_ff) * 41'(natural_freq_ff)) >> 16);
            rem_in = ((64'd1 << 32) - 64'(32'(damping_ratio_ff) * 32'(damping_ratio_ff)))
                     << 30;
            res_in   = '0;
            cnt_in   = '0;
            state_in = SEQ_ROOT;
         end
         SEQ_ROOT: begin
            // one root bit per cycle
            if (rem_ff >= root_trial) begin
               rem_in = rem_ff - root_trial;
               res_in = (res_ff >> 1) + root_bit;
            end else begin
               res_in = res_ff >> 1;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = SEQ_WD;
            end
         end
         SEQ_WD: begin
            wd_in    = 25'((57'(natural_freq_ff) * 57'(res_ff[31:0])) >> 31);
            state_in = SEQ_SQ;
         end
         SEQ_SQ: begin
            xsq_in    = (50'(xw_ff) * 50'(xw_ff)) >> FRAC_BITS;
            wsq_in    = (50'(wd_ff) * 50'(wd_ff)) >> FRAC_BITS;
            cc_mag_in = 40'((50'(xw_ff) * 50'(wd_ff)) >> (FRAC_BITS - 1));
            state_in  = SEQ_COEF;
         end
         SEQ_COEF: begin
            cs_neg_in = wsq_ff > xsq_ff;
            cs_mag_in = (wsq_ff > xsq_ff) ? 40'(wsq_ff - xsq_ff) : 40'(xsq_ff - wsq_ff);
            state_in  = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_XW;
         end
      endcase
      // a register write restarts the coefficient pass
      if (csr_write) begin
         if (csr_index == REG_NATURAL_FREQ) begin
            natural_freq_in = csr_wdata[24:0];
         end
         if (csr_index == REG_DAMPING_RATIO) begin
            damping_ratio_in = csr_wdata[15:0];
         end
         state_in = SEQ_XW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         natural_freq_ff  <= NATURAL_FREQ_RST;
         damping_ratio_ff <= DAMPING_RATIO_RST;
         state_ff         <= SEQ_XW;
      end else begin
         natural_freq_ff  <= natural_freq_in;
         damping_ratio_ff <= damping_ratio_in;
         state_ff         <= state_in;
      end
      xw_ff     <= xw_in;
      rem_ff    <= rem_in;
      res_ff    <= res_in;
      cnt_ff    <= cnt_in;
      wd_ff     <= wd_in;
      xsq_ff    <= xsq_in;
      wsq_ff    <= wsq_in;
      cc_mag_ff <= cc_mag_in;
      cs_mag_ff <= cs_mag_in;
      cs_neg_ff <= cs_neg_in;
   end

   // ---------------------------------------------------------------
   // pipeline control: everything advances together
   // ---------------------------------------------------------------
   logic adv;
   logic out_vld_ff;

   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv && (state_ff == SEQ_IDLE);

   // stage a: input beat
   logic        a_vld_ff, a_neg_ff;
   logic [30:0] a_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid && req_ready;
      end
      if (adv) begin
         a_neg_ff <= req_time_value[31];
         a_t_ff   <= req_time_value[30:0];
      end
   end

   // stage b: phase and decay products
   logic        b_vld_ff, b_neg_ff;
   logic [55:0] b_p_ff, b_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
      if (adv) begin
         b_neg_ff <= a_neg_ff;
         b_p_ff   <= 56'(wd_ff) * 56'(a_t_ff);
         b_q_ff   <= 56'(xw_ff) * 56'(a_t_ff);
      end
   end

   // stage c: scale to 32 fraction bits, radians to turns, split decay exponent
   logic        c_vld_ff, c_neg_ff, c_cut_ff;
   logic [31:0] c_hik_ff, c_lok_ff;
   logic [4:0]  c_k_ff;
   logic [29:0] c_f_ff;
   logic [63:0] p32, a32;

   always_comb begin
      p32 = (64'(b_p_ff) >> ShR) << ShL;
      a32 = (64'(b_q_ff) >> ShR) << ShL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
      if (adv) begin
         c_neg_ff <= b_neg_ff;
         c_hik_ff <= 32'(64'(p32[63:32]) * 64'(TURN_PER_RAD_Q32));
         c_lok_ff <= 32'((64'(p32[31:0]) * 64'(TURN_PER_RAD_Q32)) >> 32);
         c_cut_ff <= a32[63:32] >= 32'(EXP_CUTOFF);
         c_k_ff   <= a32[36:32];
         c_f_ff   <= a32[31:2];
      end
   end

   // stage d: turns modulo one
   logic        d_vld_ff, d_neg_ff, d_cut_ff;
   logic [31:0] d_turns_ff;
   logic [4:0]  d_k_ff;
   logic [29:0] d_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
      if (adv) begin
         d_neg_ff   <= c_neg_ff;
         d_turns_ff <= c_hik_ff + c_lok_ff;
         d_cut_ff   <= c_cut_ff;
         d_k_ff     <= c_k_ff;
         d_f_ff     <= c_f_ff;
      end
   end

   // stage e: angle within the quadrant, Q1.30
   logic        e_vld_ff, e_neg_ff, e_cut_ff;
   logic [30:0] e_x_ff;
   logic [1:0]  e_quad_ff;
   logic [4:0]  e_k_ff;
   logic [29:0] e_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
      if (adv) begin
         e_neg_ff  <= d_neg_ff;
         e_x_ff    <= 31'((64'(d_turns_ff[29:0]) * 64'(TWO_PI_Q29)) >> 31);
         e_quad_ff <= d_turns_ff[31:30];
         e_cut_ff  <= d_cut_ff;
         e_k_ff    <= d_k_ff;
         e_f_ff    <= d_f_ff;
      end
   end

   // ---------------------------------------------------------------
   // series stages: index 0 seeds, 2i-1 multiplies, 2i divides
   // ---------------------------------------------------------------
   tay_type tay_ff [0:2*TAYLOR_STEPS];
   tay_type tay0_in;

   always_comb begin
      tay0_in      = '0;
      tay0_in.vld  = e_vld_ff;
      tay0_in.neg  = e_neg_ff;
      tay0_in.cut  = e_cut_ff;
      tay0_in.quad = e_quad_ff;
      tay0_in.k    = e_k_ff;
      tay0_in.x2   = 32'((64'(e_x_ff) * 64'(e_x_ff)) >> 30);
      tay0_in.ts   = 33'(e_x_ff);
      tay0_in.tc   = 33'(ONE_Q30);
      tay0_in.ss   = $signed(33'(e_x_ff));
      tay0_in.cs   = $signed(33'(ONE_Q30));
      tay0_in.f    = e_f_ff;
      tay0_in.et   = ONE_Q30;
      tay0_in.es   = $signed(32'(ONE_Q30));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tay_ff[0].vld <= 1'b0;
      end else if (adv) begin
         tay_ff[0].vld <= tay0_in.vld;
      end
      if (adv) begin
         tay_ff[0][$bits(tay_type)-2:0] <= tay0_in[$bits(tay_type)-2:0];
      end
   end

   for (genvar i = 1; i <= TAYLOR_STEPS; i++) begin : g_tay
      localparam int  SinDiv = (2 * i) * (2 * i + 1);
      localparam int  CosDiv = (2 * i - 1) * (2 * i);
      localparam int  ExpDiv = i;
      localparam bit  Trig   = (i <= TRIG_STEPS);
      localparam bit  Odd    = (i % 2) == 1;
      // floor division by a constant as a reciprocal product, exact over the operand width
      localparam int  SinSh  = 33 + $clog2(SinDiv);
      localparam int  CosSh  = 33 + $clog2(CosDiv);
      localparam int  ExpSh  = 31 + $clog2(ExpDiv);
      localparam logic [33:0] SinMul =
         34'(((64'd1 << SinSh) + 64'(SinDiv - 1)) / 64'(SinDiv));
      localparam logic [33:0] CosMul =
         34'(((64'd1 << CosSh) + 64'(CosDiv - 1)) / 64'(CosDiv));
      localparam logic [31:0] ExpMul =
         32'(((64'd1 << ExpSh) + 64'(ExpDiv - 1)) / 64'(ExpDiv));

      tay_type mul_in, div_in;
      tay_type src;

      always_comb begin
         src    = tay_ff[2*i-2];
         mul_in = src;
         mul_in.et = 31'((62'(src.et) * 62'(src.f)) >> 30);
         if (Trig) begin
            mul_in.ts = 33'((66'(src.ts) * 66'(src.x2)) >> 30);
            mul_in.tc = 33'((66'(src.tc) * 66'(src.x2)) >> 30);
         end
      end

      always_comb begin
         div_in    = tay_ff[2*i-1];
         div_in.et = 31'((63'(tay_ff[2*i-1].et) * 63'(ExpMul)) >> ExpSh);
         div_in.es = Odd ? tay_ff[2*i-1].es - $signed({1'b0, div_in.et})
                         : tay_ff[2*i-1].es + $signed({1'b0, div_in.et});
         if (Trig) begin
            div_in.ts = 33'((67'(tay_ff[2*i-1].ts) * 67'(SinMul)) >> SinSh);
            div_in.tc = 33'((67'(tay_ff[2*i-1].tc) * 67'(CosMul)) >> CosSh);
            div_in.ss = Odd ? tay_ff[2*i-1].ss - $signed({1'b0, div_in.ts[31:0]})
                            : tay_ff[2*i-1].ss + $signed({1'b0, div_in.ts[31:0]});
            div_in.cs = Odd ? tay_ff[2*i-1].cs - $signed({1'b0, div_in.tc[31:0]})
                            : tay_ff[2*i-1].cs + $signed({1'b0, div_in.tc[31:0]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tay_ff[2*i-1].vld <= 1'b0;
            tay_ff[2*i].vld   <= 1'b0;
         end else if (adv) begin
            tay_ff[2*i-1].vld <= mul_in.vld;
            tay_ff[2*i].vld   <= div_in.vld;
         end
         if (adv) begin
            tay_ff[2*i-1][$bits(tay_type)-2:0] <= mul_in[$bits(tay_type)-2:0];
            tay_ff[2*i][$bits(tay_type)-2:0]   <= div_in[$bits(tay_type)-2:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // decay stages: quadrant unfold, then k multiplies by e^-1
   // ---------------------------------------------------------------
   dec_type dec_ff [0:DecStages];
   dec_type dec0_in;
   tay_type tay_last;
   logic signed [33:0] ssx, csx;

   always_comb begin
      tay_last    = tay_ff[2*TAYLOR_STEPS];
      ssx         = 34'(tay_last.ss);
      csx         = 34'(tay_last.cs);
      dec0_in.vld = tay_last.vld;
      dec0_in.neg = tay_last.neg;
      dec0_in.k   = tay_last.k;
      dec0_in.e   = tay_last.cut ? '0 : tay_last.es[30:0];
      case (tay_last.quad)
         QUAD_FIRST: begin
            dec0_in.sv = ssx;
            dec0_in.cv = csx;
         end
         QUAD_SECOND: begin
            dec0_in.sv = csx;
            dec0_in.cv = -ssx;
         end
         QUAD_THIRD: begin
            dec0_in.sv = -ssx;
            dec0_in.cv = -csx;
         end
         default: begin
            dec0_in.sv = -csx;
            dec0_in.cv = ssx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff[0].vld <= 1'b0;
      end else if (adv) begin
         dec_ff[0].vld <= dec0_in.vld;
      end
      if (adv) begin
         dec_ff[0][$bits(dec_type)-2:0] <= dec0_in[$bits(dec_type)-2:0];
      end
   end

   for (genvar j = 0; j < DecStages; j++) begin : g_dec
      dec_type nx_in;

      always_comb begin
         nx_in = dec_ff[j];
         if (5'(j) < dec_ff[j].k) begin
            nx_in.e = 31'((61'(dec_ff[j].e) * 61'(INV_E_Q30)) >> 30);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dec_ff[j+1].vld <= 1'b0;
         end else if (adv) begin
            dec_ff[j+1].vld <= nx_in.vld;
         end
         if (adv) begin
            dec_ff[j+1][$bits(dec_type)-2:0] <= nx_in[$bits(dec_type)-2:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // coefficient products and final scaling
   // ---------------------------------------------------------------
   dec_type dec_last;
   assign dec_last = dec_ff[DecStages];

   // g1: magnitudes and product signs
   logic        g1_vld_ff, g1_neg_ff, g1_gs_ff, g1_gc_ff;
   logic [32:0] g1_sm_ff, g1_cm_ff;
   logic [30:0] g1_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_vld_ff <= 1'b0;
      end else if (adv) begin
         g1_vld_ff <= dec_last.vld;
      end
      if (adv) begin
         g1_neg_ff <= dec_last.neg;
         g1_sm_ff  <= dec_last.sv[33] ? 33'(-dec_last.sv) : 33'(dec_last.sv);
         g1_cm_ff  <= dec_last.cv[33] ? 33'(-dec_last.cv) : 33'(dec_last.cv);
         g1_gs_ff  <= cs_neg_ff ^ dec_last.sv[33];
         g1_gc_ff  <= dec_last.cv[33];
         g1_e_ff   <= dec_last.e;
      end
   end

   // g2: partial products, coefficient split at bit 20
   logic        g2_vld_ff, g2_neg_ff, g2_gs_ff, g2_gc_ff;
   logic [52:0] g2_shi_ff, g2_slo_ff, g2_chi_ff, g2_clo_ff;
   logic [30:0] g2_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g2_vld_ff <= 1'b0;
      end else if (adv) begin
         g2_vld_ff <= g1_vld_ff;
      end
      if (adv) begin
         g2_neg_ff <= g1_neg_ff;
         g2_gs_ff  <= g1_gs_ff;
         g2_gc_ff  <= g1_gc_ff;
         g2_e_ff   <= g1_e_ff;
         g2_shi_ff <= 53'(cs_mag_ff[39:20]) * 53'(g1_sm_ff);
         g2_slo_ff <= 53'(cs_mag_ff[19:0]) * 53'(g1_sm_ff);
         g2_chi_ff <= 53'(cc_mag_ff[39:20]) * 53'(g1_cm_ff);
         g2_clo_ff <= 53'(cc_mag_ff[19:0]) * 53'(g1_cm_ff);
      end
   end

   // g3: recombine, floor by 30 bits
   logic        g3_vld_ff, g3_neg_ff, g3_gs_ff, g3_gc_ff;
   logic [42:0] g3_m1_ff, g3_m2_ff;
   logic [30:0] g3_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g3_vld_ff <= 1'b0;
      end else if (adv) begin
         g3_vld_ff <= g2_vld_ff;
      end
      if (adv) begin
         g3_neg_ff <= g2_neg_ff;
         g3_gs_ff  <= g2_gs_ff;
         g3_gc_ff  <= g2_gc_ff;
         g3_e_ff   <= g2_e_ff;
         g3_m1_ff  <= 43'(((74'(g2_shi_ff) << 20) + 74'(g2_slo_ff)) >> 30);
         g3_m2_ff  <= 43'(((74'(g2_chi_ff) << 20) + 74'(g2_clo_ff)) >> 30);
      end
   end

   // g4: signed difference of the two terms
   logic               g4_vld_ff, g4_neg_ff;
   logic signed [44:0] g4_pp_ff;
   logic [30:0]        g4_e_ff;
   logic signed [44:0] t1, t2;

   always_comb begin
      t1 = g3_gs_ff ? -$signed({2'b0, g3_m1_ff}) : $signed({2'b0, g3_m1_ff});
      t2 = g3_gc_ff ? -$signed({2'b0, g3_m2_ff}) : $signed({2'b0, g3_m2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g4_vld_ff <= 1'b0;
      end else if (adv) begin
         g4_vld_ff <= g3_vld_ff;
      end
      if (adv) begin
         g4_neg_ff <= g3_neg_ff;
         g4_e_ff   <= g3_e_ff;
         g4_pp_ff  <= t1 - t2;
      end
   end

   // g5: magnitude of the weighted sum
   logic        g5_vld_ff, g5_neg_ff, g5_pn_ff;
   logic [43:0] g5_ppm_ff;
   logic [30:0] g5_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g5_vld_ff <= 1'b0;
      end else if (adv) begin
         g5_vld_ff <= g4_vld_ff;
      end
      if (adv) begin
         g5_neg_ff <= g4_neg_ff;
         g5_e_ff   <= g4_e_ff;
         g5_pn_ff  <= g4_pp_ff[44];
         g5_ppm_ff <= g4_pp_ff[44] ? 44'(-g4_pp_ff) : 44'(g4_pp_ff);
      end
   end

   // g6: decay partial products
   logic        g6_vld_ff, g6_neg_ff, g6_pn_ff;
   logic [54:0] g6_hi_ff;
   logic [50:0] g6_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g6_vld_ff <= 1'b0;
      end else if (adv) begin
         g6_vld_ff <= g5_vld_ff;
      end
      if (adv) begin
         g6_neg_ff <= g5_neg_ff;
         g6_pn_ff  <= g5_pn_ff;
         g6_hi_ff  <= 55'(g5_ppm_ff[43:20]) * 55'(g5_e_ff);
         g6_lo_ff  <= 51'(g5_ppm_ff[19:0]) * 51'(g5_e_ff);
      end
   end

   // g7: recombine
   logic        g7_vld_ff, g7_neg_ff, g7_pn_ff;
   logic [44:0] g7_am_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g7_vld_ff <= 1'b0;
      end else if (adv) begin
         g7_vld_ff <= g6_vld_ff;
      end
      if (adv) begin
         g7_neg_ff <= g6_neg_ff;
         g7_pn_ff  <= g6_pn_ff;
         g7_am_ff  <= 45'(((76'(g6_hi_ff) << 20) + 76'(g6_lo_ff)) >> 30);
      end
   end

   // output register: sign, clip, zero for negative time
   logic signed [47:0] amp_ff, amp_in;
   logic               sat_ff, sat_in;
   logic signed [48:0] amp_wide;

   always_comb begin
      amp_wide = g7_pn_ff ? -$signed({4'b0, g7_am_ff}) : $signed({4'b0, g7_am_ff});
      sat_in   = 1'b0;
      if (g7_neg_ff) begin
         amp_in = '0;
      end else if (amp_wide > $signed({2'b00, {47{1'b1}}})) begin
         amp_in = {1'b0, {47{1'b1}}};
         sat_in = 1'b1;
      end else if (amp_wide < $signed({2'b11, {47{1'b0}}})) begin
         amp_in = {1'b1, {47{1'b0}}};
         sat_in = 1'b1;
      end else begin
         amp_in = 48'(amp_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= g7_vld_ff;
      end
      if (adv) begin
         amp_ff <= amp_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_amplitude = amp_ff;
   assign rsp_saturated = sat_ff;

endmodule
